// ----- hw/rtl/dtq_pkg.sv -----
// Shared types, field widths and codes of the delta list timer queue.
package dtq_pkg;

	// Default number of timer slots.
	localparam int TIMER_SLOTS_DEF = 64;

	// Field widths.
	localparam int DELAY_W  = 16;
	localparam int HANDLE_W = 8;

	// Stream data widths, padded to whole bytes.
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;

	// Operation codes carried on the input tuser.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	// Status codes carried on the output tuser.
	localparam logic STATUS_FIRED = 1'b0;
	localparam logic STATUS_FULL  = 1'b1;

	// Sequencer states, one-hot.
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_REPLY = 8'b0000_0010,
		S_TICK  = 8'b0000_0100,
		S_NEXT  = 8'b0000_1000,
		S_POP   = 8'b0001_0000,
		S_WALK  = 8'b0010_0000,
		S_SHIFT = 8'b0100_0000,
		S_PLACE = 8'b1000_0000
	} state_t;

endpackage

// ----- hw/rtl/delta_timer_queue.sv -----
// Top level of the delta list timer queue: sequencer, slot memory and result register.
//
// Channel  Direction  Handshake         Payload
// s_*      in         s_tvalid/tready   tuser = operation, tdata = delay, handle
// m_*      out        m_tvalid/tready   tuser = status, tdata = fired_handle, tlast = last
//
// In an insertion the walk reads one slot per cycle through the single memory read port,
// then the tail is moved one slot a cycle, then the new entry is written.
// Reset (arst_n, asynchronous) empties the queue; the slot memory needs no clearing.
// Input is taken only between items; a stalled result register holds the sequencer only
// where it needs to load another result.
module delta_timer_queue #(
	parameter int TIMER_SLOTS = dtq_pkg::TIMER_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// Fields from bit 0: delay[15:0], handle[23:16].
	input  logic [dtq_pkg::IN_DATA_W-1:0]   s_tdata,
	// Fields from bit 0: operation[0].
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// Fields from bit 0: fired_handle[7:0].
	output logic [dtq_pkg::OUT_DATA_W-1:0]  m_tdata,
	// Fields from bit 0: status[0].
	output logic                            m_tuser,
	output logic                            m_tlast
);
	import dtq_pkg::*;

	localparam int AW = $clog2(TIMER_SLOTS);
	localparam int CW = $clog2(TIMER_SLOTS + 1);
	localparam logic [CW:0] SLOTS_X = (CW+1)'(TIMER_SLOTS);

	// Map a position in the list to a slot of the circular store.
	function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] base,
		input logic [CW-1:0] offs);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(offs);
		if (sum >= SLOTS_X) begin
			sum = sum - SLOTS_X;
		end
		return sum[AW-1:0];
	endfunction

	state_t                state_q, state_d;
	logic [AW-1:0]         head_q, head_d, head_inc;
	logic [CW-1:0]         occ_q, occ_d;
	logic [CW-1:0]         walk_q, walk_d;
	logic [CW-1:0]         shf_q, shf_d;
	logic [DELAY_W-1:0]    rem_q, rem_d;
	logic [HANDLE_W-1:0]   hnd_q, hnd_d;
	logic                  rstat_q, rstat_d;

	logic [DELAY_W-1:0]    mem_delta [TIMER_SLOTS];
	logic [HANDLE_W-1:0]   mem_handle [TIMER_SLOTS];
	logic                  rd_en, wr_en;
	logic [AW-1:0]         rd_addr, wr_addr;
	logic [DELAY_W-1:0]    wr_delta, rd_delta_q;
	logic [HANDLE_W-1:0]   wr_handle, rd_handle_q;

	logic [DELAY_W-1:0]    alu_a, alu_b;
	logic [DELAY_W:0]      alu_diff;
	logic                  alu_pos;

	logic                  out_valid_q, out_status_q, out_last_q;
	logic [HANDLE_W-1:0]   out_handle_q;
	logic                  out_free, out_load, ld_status, ld_last;
	logic [HANDLE_W-1:0]   ld_handle;

	logic                  in_op;
	logic [DELAY_W-1:0]    in_delay;
	logic [HANDLE_W-1:0]   in_handle;

	assign in_op     = s_tuser;
	assign in_delay  = s_tdata[DELAY_W-1:0];
	assign in_handle = s_tdata[DELAY_W +: HANDLE_W];

	// Shared subtractor: the borrow and the zero test give the comparisons.
	assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
	assign alu_pos  = !alu_diff[DELAY_W] && (alu_diff[DELAY_W-1:0] != '0);

	assign head_inc = (head_q == AW'(TIMER_SLOTS - 1)) ? '0 : head_q + 1'b1;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	// Sequencer.
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		occ_d     = occ_q;
		walk_d    = walk_q;
		shf_d     = shf_q;
		rem_d     = rem_q;
		hnd_d     = hnd_q;
		rstat_d   = rstat_q;
		rd_en     = 1'b0;
		rd_addr   = head_q;
		wr_en     = 1'b0;
		wr_addr   = head_q;
		wr_delta  = rd_delta_q;
		wr_handle = rd_handle_q;
		alu_a     = rd_delta_q;
		alu_b     = DELAY_W'(1);
		out_load  = 1'b0;
		ld_status = STATUS_FIRED;
		ld_handle = hnd_q;
		ld_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					hnd_d  = in_handle;
					rem_d  = in_delay;
					walk_d = '0;
					if (in_op == OP_TICK) begin
						if (occ_q != '0) begin
							rd_en   = 1'b1;
							state_d = S_TICK;
						end
					end else begin
						priority if (in_handle == '0) begin
							state_d = S_IDLE;
						end else if (in_delay == '0) begin
							rstat_d = STATUS_FIRED;
							state_d = S_REPLY;
						end else if (occ_q >= CW'(TIMER_SLOTS)) begin
							rstat_d = STATUS_FULL;
							state_d = S_REPLY;
						end else begin
							rd_en   = 1'b1;
							state_d = S_WALK;
						end
					end
				end
			end
			S_REPLY: begin
				if (out_free) begin
					out_load  = 1'b1;
					ld_status = rstat_q;
					state_d   = S_IDLE;
				end
			end
			S_TICK: begin
				// Head delta above one only counts down; otherwise the head fires.
				if (alu_pos && (alu_diff[DELAY_W-1:0] != '0) && (rd_delta_q != DELAY_W'(1))) begin
					wr_en    = 1'b1;
					wr_delta = alu_diff[DELAY_W-1:0];
					state_d  = S_IDLE;
				end else begin
					hnd_d   = rd_handle_q;
					head_d  = head_inc;
					occ_d   = occ_q - 1'b1;
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				// With the list empty the pending entry is the final result.
				if (occ_q == '0) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					rd_en   = 1'b1;
					state_d = S_POP;
				end
			end
			S_POP: begin
				// The new head decides whether the pending result is the final one.
				if (out_free) begin
					out_load = 1'b1;
					if (rd_delta_q != '0) begin
						state_d = S_IDLE;
					end else begin
						ld_last = 1'b0;
						hnd_d   = rd_handle_q;
						head_d  = head_inc;
						occ_d   = occ_q - 1'b1;
						state_d = S_NEXT;
					end
				end
			end
			S_WALK: begin
				// Step past entries that expire strictly before the new one.
				alu_a = rem_q;
				alu_b = rd_delta_q;
				if ((walk_q < occ_q) && alu_pos) begin
					rem_d   = alu_diff[DELAY_W-1:0];
					walk_d  = walk_q + 1'b1;
					rd_en   = 1'b1;
					rd_addr = to_phys(head_q, walk_q + 1'b1);
				end else if (walk_q == occ_q) begin
					state_d = S_PLACE;
				end else begin
					shf_d   = occ_q;
					rd_en   = 1'b1;
					rd_addr = to_phys(head_q, occ_q - 1'b1);
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				// Move the tail up one slot; the follower loses the new entry's delta.
				alu_a   = rd_delta_q;
				alu_b   = rem_q;
				wr_en   = 1'b1;
				wr_addr = to_phys(head_q, shf_q);
				if (shf_q == walk_q + 1'b1) begin
					wr_delta = alu_diff[DELAY_W-1:0];
					state_d  = S_PLACE;
				end else begin
					shf_d   = shf_q - 1'b1;
					rd_en   = 1'b1;
					rd_addr = to_phys(head_q, shf_q - CW'(2));
				end
			end
			S_PLACE: begin
				wr_en     = 1'b1;
				wr_addr   = to_phys(head_q, walk_q);
				wr_delta  = rem_q;
				wr_handle = hnd_q;
				occ_d     = occ_q + 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			occ_q   <= occ_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and result payload registers.
	always_ff @(posedge clk) begin
		walk_q  <= walk_d;
		shf_q   <= shf_d;
		rem_q   <= rem_d;
		hnd_q   <= hnd_d;
		rstat_q <= rstat_d;
		if (out_load) begin
			out_status_q <= ld_status;
			out_handle_q <= ld_handle;
			out_last_q   <= ld_last;
		end
	end

	// Slot memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_delta[wr_addr]  <= wr_delta;
			mem_handle[wr_addr] <= wr_handle;
		end
		if (rd_en) begin
			rd_delta_q  <= mem_delta[rd_addr];
			rd_handle_q <= mem_handle[rd_addr];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_handle_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- sim/delta_timer_queue_tb.sv -----
// Self-checking testbench of the delta list timer queue, with its own model of the queue.
module delta_timer_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dtq_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int SLOTS        = TIMER_SLOTS_DEF;
	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE_TIME  = SLOTS + 16;
	localparam int RANDOM_ITEMS = 60;
	localparam int REPORT_MAX   = 10;

	// One result as it appears on the output stream.
	typedef struct packed {
		logic                status;
		logic [HANDLE_W-1:0] handle;
		logic                last;
	} timer_result_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = OP_TICK;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	// Model of the queue: deltas and handles in expiry order.
	logic [DELAY_W-1:0]  slot_delta  [SLOTS];
	logic [HANDLE_W-1:0] slot_handle [SLOTS];
	int                  live_count = 0;

	timer_result_t expected_results[$];

	int  mismatch_count = 0;
	int  items_sent     = 0;
	int  fired_seen     = 0;
	int  full_seen      = 0;
	int  most_fired     = 0;
	int  burst_left     = 0;
	bit  steady_sender  = 1'b0;
	int  idle_cycles    = 0;
	int  rx_cycle       = 0;

	delta_timer_queue #(
		.TIMER_SLOTS(SLOTS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Work out the results of one accepted item and update the queue model.
	task automatic predict_timer_item(input logic op, input logic [DELAY_W-1:0] delay,
			input logic [HANDLE_W-1:0] handle);
		timer_result_t      r;
		logic [DELAY_W-1:0] rem;
		int                 pos;
		int                 n;
		if (op == OP_ADD) begin
			if (handle == '0)
				return;
			if (delay == '0 || live_count >= SLOTS) begin
				r.status = (delay == '0) ? STATUS_FIRED : STATUS_FULL;
				r.handle = handle;
				r.last   = 1'b1;
				expected_results.push_back(r);
				return;
			end
			// Walk to the insertion point; equal expiry goes ahead of the existing entry.
			rem = delay;
			pos = 0;
			while (pos < live_count && slot_delta[pos] < rem) begin
				rem = rem - slot_delta[pos];
				pos++;
			end
			for (int j = live_count; j > pos; j--) begin
				slot_delta[j]  = slot_delta[j - 1];
				slot_handle[j] = slot_handle[j - 1];
			end
			slot_delta[pos]  = rem;
			slot_handle[pos] = handle;
			if (pos < live_count)
				slot_delta[pos + 1] = slot_delta[pos + 1] - rem;
			live_count++;
			return;
		end
		if (live_count == 0)
			return;
		if (slot_delta[0] != '0)
			slot_delta[0] = slot_delta[0] - 1'b1;
		// Fire every leading entry whose delta has reached zero.
		n = 0;
		while (live_count > 0 && slot_delta[0] == '0) begin
			r.status = STATUS_FIRED;
			r.handle = slot_handle[0];
			for (int j = 1; j < live_count; j++) begin
				slot_delta[j - 1]  = slot_delta[j];
				slot_handle[j - 1] = slot_handle[j];
			end
			live_count--;
			r.last = (live_count == 0) || (slot_delta[0] != '0);
			expected_results.push_back(r);
			n++;
		end
		if (n > most_fired)
			most_fired = n;
	endtask

	// Offer one item, wait for its transfer, then predict its results.
	task automatic send_timer_item(input logic op, input logic [DELAY_W-1:0] delay,
			input logic [HANDLE_W-1:0] handle);
		if (!steady_sender && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {handle, delay};
		do
			@(posedge clk);
		while (!s_tready);
		predict_timer_item(op, delay, handle);
		items_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	// Hold the sender back until every expected result has come out.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_tick_on_empty();
		send_timer_item(OP_TICK, 16'd0, 8'd0);
		send_timer_item(OP_TICK, 16'hFFFF, 8'hFF);
	endtask

	task automatic test_ignored_adds();
		send_timer_item(OP_ADD, 16'd0, 8'd0);
		send_timer_item(OP_ADD, 16'hFFFF, 8'd0);
		send_timer_item(OP_ADD, 16'd5, 8'd0);
		send_timer_item(OP_TICK, 16'd0, 8'd0);
	endtask

	task automatic test_immediate_fire();
		send_timer_item(OP_ADD, 16'd0, 8'hFF);
		send_timer_item(OP_ADD, 16'd0, 8'h01);
	endtask

	// Mixed delays with equal expiries; ticks then fire them in list order.
	task automatic test_expiry_order();
		send_timer_item(OP_ADD, 16'd3, 8'h10);
		send_timer_item(OP_ADD, 16'd1, 8'h20);
		send_timer_item(OP_ADD, 16'd3, 8'h30);
		send_timer_item(OP_ADD, 16'd2, 8'h40);
		send_timer_item(OP_ADD, 16'd2, 8'h41);
		repeat (3) send_timer_item(OP_TICK, 16'd0, 8'd0);
	endtask

	// Fill every slot, try adds on the full queue, then drain it.
	task automatic test_full_queue();
		wait_for_results();
		while (live_count < SLOTS)
			send_timer_item(OP_ADD, 16'd2, 8'($urandom_range(1, 255)));
		send_timer_item(OP_ADD, 16'hFFFF, 8'hC3);
		send_timer_item(OP_ADD, 16'd0, 8'hFF);
		send_timer_item(OP_ADD, 16'd7, 8'd0);
		// The second tick fires the whole queue at once.
		repeat (2) send_timer_item(OP_TICK, 16'd0, 8'd0);
		while (live_count < SLOTS)
			send_timer_item(OP_ADD, 16'($urandom_range(1, 8)), 8'($urandom_range(1, 255)));
		send_timer_item(OP_ADD, 16'($urandom_range(1, 8)), 8'($urandom_range(1, 255)));
		while (live_count > 0)
			send_timer_item(OP_TICK, 16'($urandom), 8'($urandom));
	endtask

	// Random mix of ticks and adds, mostly short delays so that timers expire.
	task automatic test_random_traffic(input int count);
		logic               op;
		logic [DELAY_W-1:0] delay;
		logic [HANDLE_W-1:0] handle;
		int                 pick;
		for (int k = 0; k < count; k++) begin
			if (k % 30 == 29)
				wait_for_results();
			steady_sender = (k >= 30 && k < 45);
			pick = $urandom_range(0, 99);
			op = (pick < ((live_count > 56) ? 60 : 40)) ? OP_TICK : OP_ADD;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				delay = '0;
			else if (pick < 8)
				delay = 16'($urandom);
			else
				delay = 16'($urandom_range(1, 24));
			handle = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
			send_timer_item(op, delay, handle);
		end
		steady_sender = 1'b0;
	endtask

	// Receiver readiness: always ready, random, or long regular stalls in turn.
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case ((rx_cycle / 256) % 3)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= (rx_cycle % 16) >= 10;
		endcase
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin : result_check
		timer_result_t want;
		if (m_tvalid && m_tready) begin
			if (m_tuser == STATUS_FULL)
				full_seen++;
			else
				fired_seen++;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("%t: unexpected result status=%0d handle=%0h last=%0d",
						$realtime, m_tuser, m_tdata, m_tlast);
			end else begin
				want = expected_results.pop_front();
				if (m_tuser !== want.status || m_tdata !== want.handle ||
						m_tlast !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display({"%t: result mismatch: expected status=%0d ",
							"handle=%0h last=%0d, got status=%0d handle=%0h last=%0d"},
							$realtime, want.status, want.handle, want.last,
							m_tuser, m_tdata, m_tlast);
				end
			end
		end
	end

	// Stop a hung run: count cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
			$display("** delta_timer_queue: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_tick_on_empty();
		test_ignored_adds();
		test_immediate_fire();
		test_expiry_order();
		test_full_queue();
		test_random_traffic(RANDOM_ITEMS);

		wait_for_results();
		repeat (SETTLE_TIME) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0d expected results never arrived", expected_results.size());
			mismatch_count += expected_results.size();
		end

		$display("Sent %0d items; saw %0d fired and %0d rejected results.",
			items_sent, fired_seen, full_seen);
		$display("Most timers fired by one tick: %0d; mismatches: %0d.",
			most_fired, mismatch_count);
		if (mismatch_count == 0)
			$display("** delta_timer_queue: PASSED **");
		else
			$display("** delta_timer_queue: FAILED **");
		$finish;
	end

endmodule
